FILE: src/m4ta_pkg.sv
// Shared types, constants and helper functions of the 4x4 matrix transform accumulator.
package m4ta_pkg;

  // Fixed-point format of the stored matrix and of the beats.
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int VAL_W     = 32;

  // Matrix geometry.
  localparam int ROWS    = 4;
  localparam int COLS    = 4;
  localparam int MAT_N   = ROWS * COLS;
  localparam int IDX_W   = $clog2(MAT_N);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAT_N - 1);

  // Arithmetic widths: one product, and a sum of one row of products.
  localparam int PROD_W = ELEM_W + VAL_W;
  localparam int SUM_W  = PROD_W + $clog2(COLS);

  // Queue sizes (powers of two).
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
  localparam int RES_DEPTH = 8;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_MUL  = 2'd1,
    OP_ADD  = 2'd2,
    OP_CMP  = 2'd3
  } op_t;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [IDX_W-1:0] element_index;
    val_t             element_value;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    val_t             result_value;
    logic             is_equal;
    logic             is_compare;
    logic             last_result;
  } out_t;

  // One complete incoming matrix together with the operation to run on it.
  typedef struct packed {
    op_t                  op;
    logic [MAT_N-1:0][VAL_W-1:0] mat;
  } cmd_t;

  localparam sum_t SAT_HI = {{(SUM_W - ELEM_W + 1){1'b0}}, {(ELEM_W - 1){1'b1}}};
  localparam sum_t SAT_LO = ~SAT_HI;

  // Clamp a wide signed value into the stored element range.
  function automatic elem_t sat_elem(input sum_t x);
    elem_t r;
    if (x > SAT_HI) begin
      r = SAT_HI[ELEM_W-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[ELEM_W-1:0];
    end else begin
      r = x[ELEM_W-1:0];
    end
    return r;
  endfunction

  localparam sum_t  ONE_WIDE = sum_t'(1) <<< FRAC_BITS;
  localparam elem_t ONE_VAL  = sat_elem(ONE_WIDE);

endpackage

FILE: src/m4ta_front.sv
// Front end: incoming element buffer and detection of the triggering element.
module m4ta_front import m4ta_pkg::*; (
  input  logic clk,
  input  logic accept,
  input  in_t  item,
  output logic cmd_push,
  output cmd_t cmd
);

  val_t elem_buf_r [MAT_N];

  always_ff @(posedge clk) begin
    if (accept) begin
      elem_buf_r[item.element_index] <= item.element_value;
    end
  end

  // The triggering beat itself supplies the last element of the snapshot.
  always_comb begin
    cmd.op = op_t'(item.operation);
    for (int i = 0; i < MAT_N; i++) begin
      cmd.mat[i] = (i == MAT_N - 1) ? item.element_value : elem_buf_r[i];
    end
    cmd_push = accept && (item.element_index == LAST_IDX);
  end

endmodule

FILE: src/m4ta_cmd_queue.sv
// Short command queue between the front end and the execution back end.
module m4ta_cmd_queue import m4ta_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t                 entry_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_W-1:0] count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full    = (count_r == CMD_CNT_W'(CMD_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: src/m4ta_res_queue.sv
// Result queue that holds finished result beats until the receiver pops them.
module m4ta_res_queue import m4ta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  out_t                 din,
  output logic [RES_CNT_W-1:0] count,
  input  logic                 pop,
  output out_t                 dout,
  output logic                 empty
);

  out_t                 entry_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] count_r, count_nxt;
  logic                 do_push, do_pop;

  assign count   = count_r;
  assign empty   = (count_r == '0);
  assign do_push = push && (count_r != RES_CNT_W'(RES_DEPTH));
  assign do_pop  = pop && !empty;
  assign dout    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + RES_CNT_W'(do_push) - RES_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: src/m4ta_back.sv
// Back end: stored matrix, three-stage multiply-accumulate pipeline and commit.
module m4ta_back import m4ta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_empty,
  input  cmd_t                 cmd,
  output logic                 cmd_pop,
  input  logic [RES_CNT_W-1:0] res_count,
  output logic                 res_push,
  output out_t                 res
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             is_cmp;
    logic             is_eq;
    logic             last;
    logic             mul;
  } tag_t;

  localparam int OCC_W = RES_CNT_W + 1;

  state_t           state_r, state_nxt;
  op_t              op_r;
  logic [IDX_W-1:0] elem_r, elem_nxt;

  // Stored matrix by rows, operand matrix by columns.
  elem_t a_r [ROWS][COLS];
  val_t  b_r [COLS][ROWS];
  elem_t n_r [MAT_N];

  logic v1_r, v2_r, v3_r;
  tag_t t1_r, t2_r, t3_r, t_issue;
  prod_t p1_r [COLS];
  sum_t  s01_r, s23_r;
  elem_t v3_val_r;

  logic             issue, room, mat_eq;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  elem_t            a_row [COLS];
  val_t             b_col [ROWS];
  prod_t            p_nxt [COLS];
  logic [OCC_W-1:0] occ;
  sum_t             total, shifted;

  assign row = elem_r[IDX_W-1:COL_W];
  assign col = elem_r[COL_W-1:0];

  always_comb begin
    for (int k = 0; k < COLS; k++) begin
      a_row[k] = a_r[row][k];
    end
    for (int k = 0; k < ROWS; k++) begin
      b_col[k] = b_r[col][k];
    end
  end

  // Exact equality of the whole stored matrix against the operand.
  always_comb begin
    mat_eq = 1'b1;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        if (a_r[r][c] != elem_t'(b_r[c][r])) begin
          mat_eq = 1'b0;
        end
      end
    end
  end

  assign occ  = OCC_W'(res_count) + OCC_W'(v1_r) + OCC_W'(v2_r) + OCC_W'(v3_r);
  assign room = (occ < OCC_W'(RES_DEPTH));

  always_comb begin
    state_nxt = state_r;
    elem_nxt  = elem_r;
    cmd_pop   = 1'b0;
    issue     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          elem_nxt  = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (room) begin
          issue = 1'b1;
          if ((op_r == OP_CMP) || (elem_r == LAST_IDX)) begin
            state_nxt = S_DRAIN;
          end else begin
            elem_nxt = elem_r + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    t_issue.idx    = (op_r == OP_CMP) ? '0 : elem_r;
    t_issue.is_cmp = (op_r == OP_CMP);
    t_issue.is_eq  = (op_r == OP_CMP) && mat_eq;
    t_issue.last   = (op_r == OP_CMP) || (elem_r == LAST_IDX);
    t_issue.mul    = (op_r == OP_MUL);
    for (int k = 0; k < COLS; k++) begin
      p_nxt[k] = '0;
    end
    case (op_r)
      OP_MUL: begin
        for (int k = 0; k < COLS; k++) begin
          p_nxt[k] = a_row[k] * b_col[k];
        end
      end
      OP_ADD: begin
        p_nxt[0] = prod_t'(a_row[col]);
        p_nxt[1] = prod_t'(b_col[row]);
      end
      OP_LOAD: begin
        p_nxt[0] = prod_t'(b_col[row]);
      end
      default: begin
        p_nxt[0] = '0;
      end
    endcase
  end

  // Final add, floor shift for products, then clamp.
  always_comb begin
    total   = s01_r + s23_r;
    shifted = t2_r.mul ? (total >>> FRAC_BITS) : total;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          a_r[r][c] <= (r == c) ? ONE_VAL : '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      if (v3_r && t3_r.last && !t3_r.is_cmp) begin
        for (int r = 0; r < ROWS; r++) begin
          for (int c = 0; c < COLS; c++) begin
            a_r[r][c] <= (t3_r.idx == IDX_W'(r * COLS + c)) ? v3_val_r
                                                             : n_r[r * COLS + c];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
    if (cmd_pop) begin
      op_r <= cmd.op;
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          b_r[c][r] <= cmd.mat[r * COLS + c];
        end
      end
    end
    t1_r <= t_issue;
    for (int k = 0; k < COLS; k++) begin
      p1_r[k] <= p_nxt[k];
    end
    t2_r     <= t1_r;
    s01_r    <= sum_t'(p1_r[0]) + sum_t'(p1_r[1]);
    s23_r    <= sum_t'(p1_r[2]) + sum_t'(p1_r[3]);
    t3_r     <= t2_r;
    v3_val_r <= sat_elem(shifted);
    if (v3_r && !t3_r.is_cmp) begin
      n_r[t3_r.idx] <= v3_val_r;
    end
  end

  always_comb begin
    res_push          = v3_r;
    res.result_index  = t3_r.idx;
    res.result_value  = t3_r.is_cmp ? '0 : val_t'(v3_val_r);
    res.is_equal      = t3_r.is_eq;
    res.is_compare    = t3_r.is_cmp;
    res.last_result   = t3_r.last;
  end

  // A new command is fetched only once the previous run has left the pipeline.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!v1_r && !v2_r && !v3_r))
    else $error("pipeline busy while back end idle");

  // The commit of the stored matrix happens while the run drains.
  a_commit_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && t3_r.last) |-> (state_r == S_DRAIN))
    else $error("last result outside drain");

  // Credit check: the result queue always has room for a finished beat.
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (res_count < RES_CNT_W'(RES_DEPTH)))
    else $error("result beat with result queue full");

  // Issue happens only during a run, and one beat enters the pipeline per issue.
  a_issue_run: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> ((state_r == S_RUN) ##1 v1_r))
    else $error("issue outside run");

endmodule

FILE: src/matrix4_transform_accumulator_core.sv
// Top level of the 4x4 fixed-point matrix transform accumulator.
//
// Usage: the block keeps one 4x4 row-major Q16.16 matrix, identity after reset.
// The input channel (in_push / in_full) takes one element beat per cycle with
// an operation code and an element index; beats come in index order 0 to 15.
// The beat with index 15 triggers the operation: load, multiply, add or
// compare. Load, multiply and add produce 16 result beats (index 0 to 15,
// last_result on index 15); compare produces one beat with is_compare set.
// The result channel (out_empty / out_pop) behaves like a queue read port.
//
// Run flow: a triggering beat passes the command queue and is fetched by the
// back end; results then leave at one per cycle while the result queue has
// room. A run is a fetch, 16 issues (compare issues only its first element)
// through the four-multiplier row datapath and a drain of the three pipeline
// stages. Element beats are taken every cycle while in_full is low; the input
// is full only while two triggered runs wait in the command queue.
//
// Reset (synchronous, active low) restores identity and empties both queues.
// When the receiver stalls, the result queue fills and the back end holds its
// issue; the front end keeps accepting beats until the command queue fills.
module matrix4_transform_accumulator_core import m4ta_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  input  in_t  in_item,
  output logic in_full,
  output logic out_empty,
  input  logic out_pop,
  output out_t out_item
);

  logic                 in_accept;
  logic                 cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t                 cmd_in, cmd_out;
  logic [RES_CNT_W-1:0] res_count;
  logic                 res_push;
  out_t                 res_beat;

  // A beat is taken whenever the command queue can absorb a possible trigger.
  assign in_full   = cmd_full;
  assign in_accept = in_push && !cmd_full;

  m4ta_front u_front (
    .clk      (clk),
    .accept   (in_accept),
    .item     (in_item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  m4ta_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  m4ta_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res       (res_beat)
  );

  m4ta_res_queue u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_beat),
    .count (res_count),
    .pop   (out_pop),
    .dout  (out_item),
    .empty (out_empty)
  );

endmodule
